// ===== hw/rtl/igvt_pkg.sv =====
// ----------------------------------------------------------------------------
// igvt_pkg: shared types and constants of the inverse Gaussian variate unit
// Register codes, item structures and datapath widths used across modules.
// ----------------------------------------------------------------------------
package igvt_pkg;

	// configuration register map
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_MU      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_LAMBDA = 2'd1;

	localparam logic [31:0] MU_RESET     = 32'h0001_0000;
	localparam logic [31:0] LAMBDA_RESET = 32'h0001_0000;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// datapath widths
	localparam int unsigned VAR_W    = 48;
	localparam int unsigned P_W      = 95;   // mu * nu^2
	localparam int unsigned D1_STEPS = 110;  // bits of w, Q.64
	localparam int unsigned SQ_STEPS = 56;   // root bits
	localparam int unsigned SQ_IN_W  = 2 * SQ_STEPS;
	localparam int unsigned SQ_REM_W = SQ_STEPS + 2;
	localparam int unsigned R_W      = SQ_STEPS + 1;
	localparam int unsigned R2_W     = 113;
	localparam int unsigned D2_STEPS = 33;   // bits of mu*2^65/R^2

	// registered stages of the back end ahead of the output register
	localparam int unsigned LAT = 4 + D1_STEPS + 1 + SQ_STEPS + 7 + D2_STEPS;

	typedef struct packed {
		logic signed [31:0] normal_sample;
		logic [31:0]        uniform_sample;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

// ===== hw/rtl/igvt_front.sv =====
// ----------------------------------------------------------------------------
// igvt_front: input queue
// Takes sample transactions and holds them until the back end advances.
// ----------------------------------------------------------------------------
module igvt_front import igvt_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  in_stall,
	output head_t head,
	input  logic  pop
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             do_pop;

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/igvt_back.sv =====
// ----------------------------------------------------------------------------
// igvt_back: variate datapath
// Squares the normal draw, divides by lambda bit by bit, takes two square
// roots bit by bit, runs the acceptance test and the final division.
// ----------------------------------------------------------------------------
module igvt_back import igvt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      mean_mu,
	input  logic [31:0]      shape_lambda,
	input  head_t            head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [VAR_W-1:0] variate,
	output logic             saturated
);

	logic            adv;
	logic [LAT-1:0]  vld_q;
	logic            out_valid_q;
	logic [31:0]     l_eff;

	assign adv          = !out_valid_q || !result_stall;
	assign pop          = adv && head.valid;
	assign result_valid = out_valid_q;
	assign l_eff        = (shape_lambda == '0) ? 32'd1 : shape_lambda;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[LAT-2:0], head.valid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// square and scale by mu
	logic [31:0]    mag_s1, z_s1;
	logic [62:0]    y_s2;
	logic [31:0]    z_s2;
	logic [63:0]    plo_s3;
	logic [62:0]    phi_s3;
	logic [31:0]    z_s3;
	logic [P_W-1:0] p_s4;
	logic [31:0]    z_s4;
	logic [63:0]    y_full;

	assign y_full = mag_s1 * mag_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= head.item.normal_sample[31] ? 32'(~head.item.normal_sample + 1'b1)
			                                      : head.item.normal_sample;
			z_s1   <= head.item.uniform_sample;
			y_s2   <= y_full[62:0];
			z_s2   <= z_s1;
			plo_s3 <= mean_mu * y_s2[31:0];
			phi_s3 <= mean_mu * y_s2[62:32];
			z_s3   <= z_s2;
			p_s4   <= P_W'(plo_s3) + (P_W'(phi_s3) << 32);
			z_s4   <= z_s3;
		end
	end

	// w = mu*y*2^15 / lambda, one quotient bit a stage
	logic [31:0]         d1_rem_s [1:D1_STEPS];
	logic [D1_STEPS-1:0] d1_nq_s  [1:D1_STEPS];
	logic [31:0]         d1_z_s   [1:D1_STEPS];

	for (genvar k = 1; k <= D1_STEPS; k++) begin : g_div1
		logic [31:0]         src_rem;
		logic [D1_STEPS-1:0] src_nq;
		logic [31:0]         src_z;
		logic [32:0]         trial;
		logic                take;
		if (k == 1) begin : g_first
			assign src_rem = '0;
			assign src_nq  = {p_s4, {(D1_STEPS - P_W){1'b0}}};
			assign src_z   = z_s4;
		end else begin : g_next
			assign src_rem = d1_rem_s[k-1];
			assign src_nq  = d1_nq_s[k-1];
			assign src_z   = d1_z_s[k-1];
		end
		assign trial = {src_rem, src_nq[D1_STEPS-1]};
		assign take  = (trial >= {1'b0, l_eff});
		always_ff @(posedge clk) begin
			if (adv) begin
				d1_rem_s[k] <= take ? 32'(trial - {1'b0, l_eff}) : trial[31:0];
				d1_nq_s[k]  <= {src_nq[D1_STEPS-2:0], take};
				d1_z_s[k]   <= src_z;
			end
		end
	end

	logic [SQ_IN_W-1:0] sq_in_s5 [2];
	logic [31:0]        z_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_in_s5[0] <= SQ_IN_W'(d1_nq_s[D1_STEPS]);
			sq_in_s5[1] <= SQ_IN_W'(d1_nq_s[D1_STEPS]) + (SQ_IN_W'(1) << 65);
			z_s5        <= d1_z_s[D1_STEPS];
		end
	end

	// sqrt(w) and sqrt(w + 2), one root bit a stage in each lane
	logic [SQ_IN_W-1:0]  sq_n_s   [1:SQ_STEPS][2];
	logic [SQ_STEPS-1:0] sq_q_s   [1:SQ_STEPS][2];
	logic [SQ_REM_W-1:0] sq_rem_s [1:SQ_STEPS][2];
	logic [31:0]         sq_z_s   [1:SQ_STEPS];

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
		logic [31:0] src_z;
		if (k == 1) begin : g_first_z
			assign src_z = z_s5;
		end else begin : g_next_z
			assign src_z = sq_z_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_z_s[k] <= src_z;
			end
		end
		for (genvar ln = 0; ln < 2; ln++) begin : g_lane
			logic [SQ_IN_W-1:0]  src_n;
			logic [SQ_STEPS-1:0] src_q;
			logic [SQ_REM_W-1:0] src_rem;
			logic [SQ_REM_W+1:0] trial;
			logic [SQ_REM_W+1:0] dtry;
			logic                take;
			if (k == 1) begin : g_first
				assign src_n   = sq_in_s5[ln];
				assign src_q   = '0;
				assign src_rem = '0;
			end else begin : g_next
				assign src_n   = sq_n_s[k-1][ln];
				assign src_q   = sq_q_s[k-1][ln];
				assign src_rem = sq_rem_s[k-1][ln];
			end
			assign trial = {src_rem, src_n[SQ_IN_W-1 -: 2]};
			assign dtry  = (SQ_REM_W + 2)'({src_q, 2'b01});
			assign take  = (trial >= dtry);
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_n_s[k][ln]   <= {src_n[SQ_IN_W-3:0], 2'b00};
					sq_q_s[k][ln]   <= {src_q[SQ_STEPS-2:0], take};
					sq_rem_s[k][ln] <= take ? SQ_REM_W'(trial - dtry) : trial[SQ_REM_W-1:0];
				end
			end
		end
	end

	// R = A + B, R^2, and the products against z and mu
	logic [R_W-1:0]  r_s6;
	logic [31:0]     z_s6;
	logic [49:0]     hh_s7;
	logic [56:0]     hl_s7;
	logic [63:0]     ll_s7;
	logic [31:0]     z_s7;
	logic [R2_W-1:0] r2_s8;
	logic [31:0]     z_s8;
	logic [63:0]     pz_s9 [3];
	logic [48:0]     pz3_s9;
	logic [63:0]     pm_s9 [3];
	logic [48:0]     pm3_s9;
	logic [R2_W-1:0] r2_s9;
	logic [31:0]     z_s9;
	logic [95:0]     zp01_s10, mp01_s10;
	logic [80:0]     zp23_s10, mp23_s10;
	logic [R2_W-1:0] r2_s10;
	logic [31:0]     z_s10;
	logic [145:0]    lhs_s11;
	logic [144:0]    mr_s11;
	logic [R2_W-1:0] r2_s11;
	logic            root_s12;
	logic [VAR_W-1:0] alt_var_s12;
	logic            alt_sat_s12;
	logic [R2_W-1:0] r2_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s6  <= R_W'(sq_q_s[SQ_STEPS][0]) + R_W'(sq_q_s[SQ_STEPS][1]);
			z_s6  <= sq_z_s[SQ_STEPS];
			hh_s7 <= r_s6[R_W-1:32] * r_s6[R_W-1:32];
			hl_s7 <= r_s6[R_W-1:32] * r_s6[31:0];
			ll_s7 <= r_s6[31:0] * r_s6[31:0];
			z_s7  <= z_s6;
			r2_s8 <= (R2_W'(hh_s7) << 64) + (R2_W'(hl_s7) << 33) + R2_W'(ll_s7);
			z_s8  <= z_s7;
			for (int i = 0; i < 3; i++) begin
				pz_s9[i] <= r2_s8[32*i +: 32] * z_s8;
				pm_s9[i] <= r2_s8[32*i +: 32] * mean_mu;
			end
			pz3_s9   <= r2_s8[R2_W-1:96] * z_s8;
			pm3_s9   <= r2_s8[R2_W-1:96] * mean_mu;
			r2_s9    <= r2_s8;
			z_s9     <= z_s8;
			zp01_s10 <= 96'(pz_s9[0]) + (96'(pz_s9[1]) << 32);
			zp23_s10 <= 81'(pz_s9[2]) + (81'(pz3_s9) << 32);
			mp01_s10 <= 96'(pm_s9[0]) + (96'(pm_s9[1]) << 32);
			mp23_s10 <= 81'(pm_s9[2]) + (81'(pm3_s9) << 32);
			r2_s10   <= r2_s9;
			z_s10    <= z_s9;
			// z*2^65 + z*R^2, set against R^2*2^32
			lhs_s11  <= 146'(zp01_s10) + (146'(zp23_s10) << 64) + (146'(z_s10) << 65);
			mr_s11   <= 145'(mp01_s10) + (145'(mp23_s10) << 64);
			r2_s11   <= r2_s10;
			root_s12    <= (lhs_s11 <= {1'b0, r2_s11, 32'b0});
			alt_sat_s12 <= |mr_s11[144:113];
			alt_var_s12 <= (|mr_s11[144:113]) ? {VAR_W{1'b1}} : mr_s11[112:65];
			r2_s12      <= r2_s11;
		end
	end

	// mu*2^65 / R^2, one quotient bit a stage
	logic [R2_W-1:0]     d2_rem_s  [1:D2_STEPS];
	logic [D2_STEPS-1:0] d2_q_s    [1:D2_STEPS];
	logic [R2_W-1:0]     d2_den_s  [1:D2_STEPS];
	logic                d2_root_s [1:D2_STEPS];
	logic [VAR_W-1:0]    d2_var_s  [1:D2_STEPS];
	logic                d2_sat_s  [1:D2_STEPS];

	for (genvar k = 1; k <= D2_STEPS; k++) begin : g_div2
		logic [R2_W-1:0]     src_rem;
		logic [D2_STEPS-1:0] src_q;
		logic [R2_W-1:0]     src_den;
		logic                src_root;
		logic [VAR_W-1:0]    src_var;
		logic                src_sat;
		logic [R2_W:0]       trial;
		logic                take;
		if (k == 1) begin : g_first
			assign src_rem  = R2_W'(mean_mu) << 32;
			assign src_q    = '0;
			assign src_den  = r2_s12;
			assign src_root = root_s12;
			assign src_var  = alt_var_s12;
			assign src_sat  = alt_sat_s12;
		end else begin : g_next
			assign src_rem  = d2_rem_s[k-1];
			assign src_q    = d2_q_s[k-1];
			assign src_den  = d2_den_s[k-1];
			assign src_root = d2_root_s[k-1];
			assign src_var  = d2_var_s[k-1];
			assign src_sat  = d2_sat_s[k-1];
		end
		assign trial = {src_rem, 1'b0};
		assign take  = (trial >= {1'b0, src_den});
		always_ff @(posedge clk) begin
			if (adv) begin
				d2_rem_s[k]  <= take ? R2_W'(trial - {1'b0, src_den}) : trial[R2_W-1:0];
				d2_q_s[k]    <= {src_q[D2_STEPS-2:0], take};
				d2_den_s[k]  <= src_den;
				d2_root_s[k] <= src_root;
				d2_var_s[k]  <= src_var;
				d2_sat_s[k]  <= src_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			variate   <= d2_root_s[D2_STEPS] ? VAR_W'(d2_q_s[D2_STEPS]) : d2_var_s[D2_STEPS];
			saturated <= !d2_root_s[D2_STEPS] && d2_sat_s[D2_STEPS];
		end
	end

endmodule

// ===== hw/rtl/inverse_gaussian_variate_transform_unit.sv =====
// ----------------------------------------------------------------------------
// inverse_gaussian_variate_transform_unit: inverse Gaussian variate transform
// Turns one normal and one uniform draw into one inverse Gaussian variate.
//
//   channel   signals                                      role
//   sample    sample_valid sample_stall normal_sample      item in
//             uniform_sample
//   result    result_valid result_stall variate saturated  item out
//   cfg       cfg_valid cfg_ready cfg_index cfg_data       register write
//
// One transaction is taken every cycle while no result stall holds the back end.
// The two bit-serial dividers (110 and 33 stages) and the two 56-stage square
// root lanes make up most of the pipeline. A result stall freezes the whole
// back end while a result is held; the input queue keeps taking samples until
// full. Reset clears all valid state and loads mu = lambda = 1.0.
// ----------------------------------------------------------------------------
module inverse_gaussian_variate_transform_unit import igvt_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic signed [31:0]   normal_sample,
	input  logic [31:0]          uniform_sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [VAR_W-1:0]     variate,
	output logic                 saturated,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [31:0] mean_mu_q;
	logic [31:0] shape_lambda_q;
	item_t       in_item;
	head_t       head;
	logic        pop;

	assign cfg_ready = 1'b1;

	// drop writes to unmapped indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_mu_q      <= MU_RESET;
			shape_lambda_q <= LAMBDA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MEAN_MU) begin
				mean_mu_q <= cfg_data;
			end else if (cfg_index == CFG_SHAPE_LAMBDA) begin
				shape_lambda_q <= cfg_data;
			end
		end
	end

	assign in_item.normal_sample  = normal_sample;
	assign in_item.uniform_sample = uniform_sample;

	igvt_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample_valid),
		.in_item (in_item),
		.in_stall(sample_stall),
		.head    (head),
		.pop     (pop)
	);

	igvt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mean_mu     (mean_mu_q),
		.shape_lambda(shape_lambda_q),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.variate     (variate),
		.saturated   (saturated)
	);

endmodule
